/* hdl/pfpsm_pkg.sv */
package pfpsm_pkg;

    localparam int MAX_CHANNELS_DEF = 8;
    localparam int COUNT_BITS_DEF   = 32;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LENGTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_COUNT   = 2'd2;

    localparam logic [3:0]  RST_CHANNEL_COUNT = 4'd2;
    localparam logic [31:0] RST_FRAME_LENGTH  = 32'd48234496;
    localparam logic [15:0] RST_FRAME_COUNT   = 16'd1;

    localparam logic [47:0] ROUND_HALF = 48'h0000_0000_8000;

    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_TOTALS = 1'b1;

    localparam int QUEUE_DEPTH = 3;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_sample;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] frame_number;
        logic [15:0] frame_peak_abs;
        logic [15:0] frame_max_jump;
        logic [15:0] stream_peak_abs;
        logic [31:0] nonzero_samples;
        logic [62:0] square_sum;
        logic        final_result;
    } out_item_t;

endpackage

/* hdl/pcm_frame_peak_step_meter_unit.sv */
// PCM frame peak and step meter.
// The s_ channel takes one interleaved signed 16-bit sample per item, with
// last_sample marking the end of a stream. The m_ channel returns result
// items: one frame statistics item each time a frame boundary is crossed,
// and on the last sample the open frame followed by the whole-stream totals.
// Frame boundaries come from a Q32.16 accumulator of the Q16.16 frame
// length, rounded and aligned down to whole interleaved groups.
// An accepted item is held in the input register and measured from there;
// its results are written into the result queue, whose head drives m_item.
// One item is taken per cycle while the queue has room for its results. An
// item that closes a frame or ends the stream needs one to three result
// slots in a three-entry result queue, so the sustained rate is bounded by
// the single result port.
// When m_ready is low, the queue and then the input register fill and
// s_ready drops; nothing is lost. Reset empties both and loads the default
// configuration. A write to a used configuration index restarts the measurement.
module pcm_frame_peak_step_meter_unit #(
    parameter int MAX_CHANNELS = pfpsm_pkg::MAX_CHANNELS_DEF,
    parameter int COUNT_BITS   = pfpsm_pkg::COUNT_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [pfpsm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pfpsm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  pfpsm_pkg::in_item_t                s_item,
    output logic                               m_valid,
    input  logic                               m_ready,
    output pfpsm_pkg::out_item_t               m_item
);

    localparam int EFF_W = $clog2(MAX_CHANNELS + 1);
    localparam int PH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CMP_W = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;
    localparam int QD    = pfpsm_pkg::QUEUE_DEPTH;
    localparam logic [EFF_W-1:0] SIF_MAX = EFF_W'(MAX_CHANNELS);
    localparam logic [47:0] RST_ACC =
        {16'd0, pfpsm_pkg::RST_FRAME_LENGTH} + pfpsm_pkg::ROUND_HALF;

    function automatic logic [EFF_W-1:0] eff_chan(input logic [3:0] cc);
        logic [EFF_W-1:0] r;
        if (cc == 4'd0) begin
            r = EFF_W'(1);
        end else if (int'(cc) > MAX_CHANNELS) begin
            r = EFF_W'(MAX_CHANNELS);
        end else begin
            r = EFF_W'(cc);
        end
        return r;
    endfunction

    function automatic logic [31:0] eff_len(input logic [3:0] cc, input logic [31:0] len);
        logic [31:0] minl;
        minl = 32'(eff_chan(cc)) << 16;
        return (len < minl) ? minl : len;
    endfunction

    // Configuration
    logic [3:0]  chan_cnt_reg, chan_cnt_next;
    logic [31:0] frame_len_reg, frame_len_next;
    logic [15:0] frame_cnt_reg, frame_cnt_next;
    logic        cfg_restart;
    logic [47:0] acc_restart;

    // Input stage
    logic                 in_valid_reg, in_valid_next;
    pfpsm_pkg::in_item_t  in_item_reg;
    logic                 s_fire;
    logic                 proc_en;

    // Measurement state
    logic [47:0]           acc_reg, acc_next;
    logic [COUNT_BITS-1:0] pos_reg, pos_next;
    logic [PH_W-1:0]       phase_reg, phase_next;
    logic [15:0]           cur_frame_reg, cur_frame_next;
    logic [EFF_W-1:0]      sif_reg, sif_next;
    logic [15:0]           fpk_reg, fpk_next;
    logic [15:0]           fjmp_reg, fjmp_next;
    logic [15:0]           spk_reg, spk_next;
    logic [31:0]           nz_reg, nz_next;
    logic [62:0]           sq_reg, sq_next;
    logic [15:0]           prev_reg [MAX_CHANNELS];

    // Result queue
    pfpsm_pkg::out_item_t  q_reg   [QD];
    pfpsm_pkg::out_item_t  q_shift [QD];
    pfpsm_pkg::out_item_t  q_next  [QD];
    pfpsm_pkg::out_item_t  gen     [QD];
    logic [1:0]            gen_idx [QD];
    logic [QD-1:0]         wr_hit;
    logic [1:0]            q_cnt_reg, q_cnt_next;
    logic                  pop;
    logic [1:0]            base;
    logic [1:0]            needed;
    logic                  room;

    // Datapath
    logic [EFF_W-1:0]  chan_eff;
    logic [31:0]       len_eff;
    logic [15:0]       frames_eff;
    logic [15:0]       raw;
    logic [15:0]       a;
    logic              frame_open;
    logic [CMP_W-1:0]  grp_end;
    logic [CMP_W-1:0]  bound;
    logic              close;
    logic [PH_W-1:0]   ph_eff;
    logic [EFF_W-1:0]  sif_base;
    logic [15:0]       fpk_base;
    logic [15:0]       fjmp_base;
    logic [15:0]       prev;
    logic [16:0]       diff;
    logic [16:0]       diff_abs;
    logic [15:0]       fpk_new;
    logic [15:0]       fjmp_new;
    logic [15:0]       spk_new;
    logic [31:0]       nz_new;
    logic [31:0]       sq_item;
    logic [63:0]       sq_sum;
    logic [62:0]       sq_new;
    logic [COUNT_BITS-1:0] pos_new;
    logic [15:0]       cf_new;
    logic [47:0]       acc_new;
    logic [EFF_W-1:0]  ph_inc;
    logic [PH_W-1:0]   phase_new;
    logic [EFF_W-1:0]  sif_new;
    pfpsm_pkg::out_item_t res_close;
    pfpsm_pkg::out_item_t res_frame;
    pfpsm_pkg::out_item_t res_tot;

    always_comb begin
        chan_cnt_next  = chan_cnt_reg;
        frame_len_next = frame_len_reg;
        frame_cnt_next = frame_cnt_reg;
        cfg_restart    = 1'b0;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                pfpsm_pkg::CFG_CHANNEL_COUNT: begin
                    chan_cnt_next = cfg_wdata[3:0];
                    cfg_restart   = 1'b1;
                end
                pfpsm_pkg::CFG_FRAME_LENGTH: begin
                    frame_len_next = cfg_wdata[31:0];
                    cfg_restart    = 1'b1;
                end
                pfpsm_pkg::CFG_FRAME_COUNT: begin
                    frame_cnt_next = cfg_wdata[15:0];
                    cfg_restart    = 1'b1;
                end
                default: begin
                    cfg_restart = 1'b0;
                end
            endcase
        end
    end

    assign acc_restart = {16'd0, eff_len(chan_cnt_next, frame_len_next)} + pfpsm_pkg::ROUND_HALF;

    assign chan_eff   = eff_chan(chan_cnt_reg);
    assign len_eff    = eff_len(chan_cnt_reg, frame_len_reg);
    assign frames_eff = (frame_cnt_reg == 16'd0) ? 16'd1 : frame_cnt_reg;

    // The phase equals the position modulo the channel count, so the aligned
    // boundary is reached once the end of the current group passes it.
    assign raw        = in_item_reg.sample;
    assign a          = raw[15] ? (~raw + 16'd1) : raw;
    assign frame_open = ({1'b0, cur_frame_reg} + 17'd1) < {1'b0, frames_eff};
    assign grp_end    = CMP_W'(pos_reg) + CMP_W'(chan_eff - EFF_W'(phase_reg));
    assign bound      = CMP_W'(acc_reg[47:16]);
    assign close      = frame_open && (grp_end > bound);

    assign ph_eff    = close ? '0 : phase_reg;
    assign sif_base  = close ? '0 : sif_reg;
    assign fpk_base  = close ? 16'd0 : fpk_reg;
    assign fjmp_base = close ? 16'd0 : fjmp_reg;
    assign prev      = prev_reg[ph_eff];
    assign diff      = {raw[15], raw} - {prev[15], prev};
    assign diff_abs  = diff[16] ? (~diff + 17'd1) : diff;

    assign fpk_new  = (a > fpk_base) ? a : fpk_base;
    assign fjmp_new = ((sif_base >= chan_eff) && (diff_abs[15:0] > fjmp_base)) ?
                      diff_abs[15:0] : fjmp_base;
    assign spk_new  = (a > spk_reg) ? a : spk_reg;
    assign nz_new   = ((raw != 16'd0) && (nz_reg != '1)) ? nz_reg + 32'd1 : nz_reg;
    assign sq_item  = a * a;
    assign sq_sum   = {1'b0, sq_reg} + {32'd0, sq_item};
    assign sq_new   = sq_sum[63] ? '1 : sq_sum[62:0];
    assign pos_new  = (pos_reg == '1) ? pos_reg : pos_reg + COUNT_BITS'(1);
    assign cf_new   = cur_frame_reg + 16'(close);
    assign acc_new  = close ? acc_reg + {16'd0, len_eff} : acc_reg;
    assign ph_inc   = EFF_W'(ph_eff) + EFF_W'(1);
    assign phase_new = (ph_inc == chan_eff) ? '0 : PH_W'(ph_inc);
    assign sif_new  = (sif_base == SIF_MAX) ? sif_base : sif_base + EFF_W'(1);

    always_comb begin
        res_close                 = '0;
        res_close.result_kind     = pfpsm_pkg::KIND_FRAME;
        res_close.frame_number    = cur_frame_reg;
        res_close.frame_peak_abs  = fpk_reg;
        res_close.frame_max_jump  = fjmp_reg;

        res_frame                 = '0;
        res_frame.result_kind     = pfpsm_pkg::KIND_FRAME;
        res_frame.frame_number    = cf_new;
        res_frame.frame_peak_abs  = fpk_new;
        res_frame.frame_max_jump  = fjmp_new;

        res_tot                   = '0;
        res_tot.result_kind       = pfpsm_pkg::KIND_TOTALS;
        res_tot.stream_peak_abs   = spk_new;
        res_tot.nonzero_samples   = nz_new;
        res_tot.square_sum        = sq_new;
        res_tot.final_result      = 1'b1;
    end

    assign gen[0] = close ? res_close : res_frame;
    assign gen[1] = close ? res_frame : res_tot;
    assign gen[2] = res_tot;

    assign needed = 2'(close) + (in_item_reg.last_sample ? 2'd2 : 2'd0);
    assign pop    = (q_cnt_reg != 2'd0) && m_ready;
    assign base   = q_cnt_reg - 2'(pop);
    assign room   = ({1'b0, base} + {1'b0, needed}) <= 3'(QD);

    assign proc_en = in_valid_reg && room;
    assign s_ready = !in_valid_reg || proc_en;
    assign s_fire  = s_valid && s_ready;

    for (genvar gi = 0; gi < QD; gi++) begin : g_queue
        if (gi < QD - 1) begin : g_mid
            assign q_shift[gi] = pop ? q_reg[gi+1] : q_reg[gi];
        end else begin : g_tail
            assign q_shift[gi] = q_reg[gi];
        end
        assign wr_hit[gi]  = proc_en && (3'(gi) >= {1'b0, base}) &&
                             (3'(gi) < ({1'b0, base} + {1'b0, needed}));
        assign gen_idx[gi] = 2'(gi) - base;
        assign q_next[gi]  = wr_hit[gi] ? gen[gen_idx[gi]] : q_shift[gi];
    end

    assign q_cnt_next = base + (proc_en ? needed : 2'd0);
    assign m_valid    = (q_cnt_reg != 2'd0);
    assign m_item     = q_reg[0];

    assign in_valid_next = s_fire ? 1'b1 : (proc_en ? 1'b0 : in_valid_reg);

    always_comb begin
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        phase_next     = phase_reg;
        cur_frame_next = cur_frame_reg;
        sif_next       = sif_reg;
        fpk_next       = fpk_reg;
        fjmp_next      = fjmp_reg;
        spk_next       = spk_reg;
        nz_next        = nz_reg;
        sq_next        = sq_reg;
        if (cfg_restart || (proc_en && in_item_reg.last_sample)) begin
            acc_next       = acc_restart;
            pos_next       = '0;
            phase_next     = '0;
            cur_frame_next = 16'd0;
            sif_next       = '0;
            fpk_next       = 16'd0;
            fjmp_next      = 16'd0;
            spk_next       = 16'd0;
            nz_next        = 32'd0;
            sq_next        = '0;
        end else if (proc_en) begin
            acc_next       = acc_new;
            pos_next       = pos_new;
            phase_next     = phase_new;
            cur_frame_next = cf_new;
            sif_next       = sif_new;
            fpk_next       = fpk_new;
            fjmp_next      = fjmp_new;
            spk_next       = spk_new;
            nz_next        = nz_new;
            sq_next        = sq_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_cnt_reg  <= pfpsm_pkg::RST_CHANNEL_COUNT;
            frame_len_reg <= pfpsm_pkg::RST_FRAME_LENGTH;
            frame_cnt_reg <= pfpsm_pkg::RST_FRAME_COUNT;
            in_valid_reg  <= 1'b0;
            q_cnt_reg     <= 2'd0;
            acc_reg       <= RST_ACC;
            pos_reg       <= '0;
            phase_reg     <= '0;
            cur_frame_reg <= 16'd0;
            sif_reg       <= '0;
            fpk_reg       <= 16'd0;
            fjmp_reg      <= 16'd0;
            spk_reg       <= 16'd0;
            nz_reg        <= 32'd0;
            sq_reg        <= '0;
        end else begin
            chan_cnt_reg  <= chan_cnt_next;
            frame_len_reg <= frame_len_next;
            frame_cnt_reg <= frame_cnt_next;
            in_valid_reg  <= in_valid_next;
            q_cnt_reg     <= q_cnt_next;
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            cur_frame_reg <= cur_frame_next;
            sif_reg       <= sif_next;
            fpk_reg       <= fpk_next;
            fjmp_reg      <= fjmp_next;
            spk_reg       <= spk_next;
            nz_reg        <= nz_next;
            sq_reg        <= sq_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= s_item;
        end
        if (proc_en) begin
            prev_reg[ph_eff] <= raw;
        end
        for (int i = 0; i < QD; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

/* hdl/pfpsm_checker.sv */
module pfpsm_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  pfpsm_pkg::out_item_t               m_item
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered right after reset");

    a_totals_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.result_kind == pfpsm_pkg::KIND_TOTALS |->
            m_item.final_result && m_item.frame_number == 16'd0 &&
            m_item.frame_peak_abs == 16'd0 && m_item.frame_max_jump == 16'd0 &&
            m_item.stream_peak_abs <= 16'd32768)
        else $error("malformed totals item");

    a_frame_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.result_kind == pfpsm_pkg::KIND_FRAME |->
            !m_item.final_result && m_item.stream_peak_abs == 16'd0 &&
            m_item.nonzero_samples == 32'd0 && m_item.square_sum == 63'd0 &&
            m_item.frame_peak_abs <= 16'd32768)
        else $error("malformed frame item");

endmodule

bind pcm_frame_peak_step_meter_unit pfpsm_checker u_pfpsm_checker (.*);

/* verif/pcm_frame_peak_step_meter_unit_tb.sv */
`timescale 1ns / 1ps

module pcm_frame_peak_step_meter_unit_tb;

    localparam int RANDOM_ITEMS  = 155;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 2000;
    localparam logic [pfpsm_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam logic [63:0] SQUARE_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    typedef struct {
        row_kind_t                         kind;
        logic [pfpsm_pkg::CFG_INDEX_W-1:0] index;
        logic [pfpsm_pkg::CFG_DATA_W-1:0]  value;
        pfpsm_pkg::in_item_t               item;
        int                                n_typed;
        pfpsm_pkg::out_item_t              typed_a;
        pfpsm_pkg::out_item_t              typed_b;
    } stim_row_t;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      cfg_wr_en = 1'b0;
    logic [pfpsm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [pfpsm_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    pfpsm_pkg::in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    pfpsm_pkg::out_item_t m_item;

    pcm_frame_peak_step_meter_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Predictor copy of the configuration and measurement state.
    logic [3:0]  cfg_channels;
    logic [31:0] cfg_length;
    logic [15:0] cfg_frames;
    logic [47:0] acc_q16;
    logic [31:0] sample_pos;
    int unsigned chan_phase;
    logic [15:0] frame_idx;
    logic [31:0] frame_fill;
    int          prev_sample [pfpsm_pkg::MAX_CHANNELS_DEF];
    logic [15:0] seg_peak;
    logic [15:0] frame_jump;
    logic [15:0] stream_peak;
    logic [31:0] nonzero_cnt;
    logic [62:0] square_acc;

    pfpsm_pkg::out_item_t step_results[$];
    pfpsm_pkg::out_item_t expected_results[$];
    stim_row_t stim_rows[$];
    pfpsm_pkg::out_item_t oldest;

    int error_count     = 0;
    int results_checked = 0;
    int items_sent      = 0;
    int streams_done    = 0;
    int writes_done     = 0;
    int idle_cycles     = 0;
    int hold_left       = 0;
    int ready_roll;
    int row_i;
    int stream_i;
    int stream_len;
    int stream_total;
    int smp_i;
    int writes_in_phase;
    int roll;
    int unsigned pick_chans;
    int unsigned base_len;
    pfpsm_pkg::in_item_t next_item;

    function automatic int unsigned eff_channels();
        int unsigned c;
        c = 32'(cfg_channels);
        if (c == 0) c = 1;
        if (c > pfpsm_pkg::MAX_CHANNELS_DEF) c = pfpsm_pkg::MAX_CHANNELS_DEF;
        return c;
    endfunction

    function automatic logic [47:0] eff_length();
        logic [47:0] min_len;
        min_len = 48'(eff_channels()) << 16;
        return (48'(cfg_length) < min_len) ? min_len : 48'(cfg_length);
    endfunction

    function automatic pfpsm_pkg::out_item_t frame_result(input logic [15:0] num,
                                                          input logic [15:0] peak,
                                                          input logic [15:0] jump);
        pfpsm_pkg::out_item_t r;
        r = '0;
        r.result_kind    = pfpsm_pkg::KIND_FRAME;
        r.frame_number   = num;
        r.frame_peak_abs = peak;
        r.frame_max_jump = jump;
        return r;
    endfunction

    function automatic pfpsm_pkg::out_item_t totals_result(input logic [15:0] peak,
                                                           input logic [31:0] nz,
                                                           input logic [62:0] sq);
        pfpsm_pkg::out_item_t r;
        r = '0;
        r.result_kind     = pfpsm_pkg::KIND_TOTALS;
        r.stream_peak_abs = peak;
        r.nonzero_samples = nz;
        r.square_sum      = sq;
        r.final_result    = 1'b1;
        return r;
    endfunction

    function automatic void meter_restart();
        acc_q16     = eff_length();
        sample_pos  = '0;
        chan_phase  = 0;
        frame_idx   = '0;
        frame_fill  = '0;
        foreach (prev_sample[i]) prev_sample[i] = 0;
        seg_peak    = '0;
        frame_jump  = '0;
        stream_peak = '0;
        nonzero_cnt = '0;
        square_acc  = '0;
    endfunction

    function automatic void meter_config(input logic [pfpsm_pkg::CFG_INDEX_W-1:0] idx,
                                         input logic [pfpsm_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            pfpsm_pkg::CFG_CHANNEL_COUNT: cfg_channels = value[3:0];
            pfpsm_pkg::CFG_FRAME_LENGTH:  cfg_length = value[31:0];
            pfpsm_pkg::CFG_FRAME_COUNT:   cfg_frames = value[15:0];
            default:                      return;
        endcase
        meter_restart();
    endfunction

    function automatic void meter_step(input pfpsm_pkg::in_item_t it);
        int unsigned chans;
        int unsigned frames;
        int unsigned ph;
        logic [47:0] bound_pos;
        logic [63:0] sq;
        int v;
        int a;
        int d;
        step_results.delete();
        chans  = eff_channels();
        frames = (cfg_frames == 16'd0) ? 1 : 32'(cfg_frames);
        v  = int'(it.sample);
        a  = (v < 0) ? -v : v;
        ph = chan_phase % chans;
        if (32'(frame_idx) + 1 < frames) begin
            bound_pos = (acc_q16 + pfpsm_pkg::ROUND_HALF) >> 16;
            bound_pos = bound_pos - (bound_pos % 48'(chans));
            if ({16'd0, sample_pos} >= bound_pos) begin
                step_results = {step_results, frame_result(frame_idx, seg_peak, frame_jump)};
                seg_peak   = '0;
                frame_jump = '0;
                frame_fill = '0;
                ph         = 0;
                frame_idx  = frame_idx + 16'd1;
                acc_q16    = acc_q16 + eff_length();
            end
        end
        if (a > int'(seg_peak)) seg_peak = a[15:0];
        if (a > int'(stream_peak)) stream_peak = a[15:0];
        if (v != 0 && nonzero_cnt != '1) nonzero_cnt = nonzero_cnt + 32'd1;
        sq = 64'(a) * 64'(a);
        if ({1'b0, square_acc} > SQUARE_LIMIT - sq) square_acc = SQUARE_LIMIT[62:0];
        else square_acc = square_acc + sq[62:0];
        if (frame_fill >= chans) begin
            d = v - prev_sample[ph];
            if (d < 0) d = -d;
            if (d > int'(frame_jump)) frame_jump = d[15:0];
        end
        prev_sample[ph] = v;
        chan_phase = (ph + 1) % chans;
        if (frame_fill != '1) frame_fill = frame_fill + 32'd1;
        if (sample_pos != '1) sample_pos = sample_pos + 32'd1;
        if (it.last_sample) begin
            step_results = {step_results, frame_result(frame_idx, seg_peak, frame_jump)};
            step_results = {step_results,
                            totals_result(stream_peak, nonzero_cnt, square_acc)};
            meter_restart();
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        if (r < 98) return $urandom_range(20, 40);
        return -1;
    endfunction

    function automatic logic [15:0] pick_sample();
        int r;
        int s;
        r = $urandom_range(0, 99);
        if (r < 15) return 16'h0000;
        if (r < 25) begin
            case ($urandom_range(0, 3))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'hFFFF;
                default: return 16'h0001;
            endcase
        end
        if (r < 55) begin
            s = $urandom_range(0, 600);
            s = s - 300;
            return s[15:0];
        end
        return 16'($urandom());
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic add_write(input logic [pfpsm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [pfpsm_pkg::CFG_DATA_W-1:0] value);
        stim_row_t row;
        row.kind    = ROW_WRITE;
        row.index   = idx;
        row.value   = value;
        row.item    = '0;
        row.n_typed = 0;
        row.typed_a = '0;
        row.typed_b = '0;
        stim_rows   = {stim_rows, row};
    endtask

    task automatic add_sample(input logic [15:0] smp, input logic last, input int n_typed,
                              input pfpsm_pkg::out_item_t ta, input pfpsm_pkg::out_item_t tb);
        stim_row_t row;
        row.kind             = ROW_SAMPLE;
        row.index            = '0;
        row.value            = '0;
        row.item.sample      = smp;
        row.item.last_sample = last;
        row.n_typed          = n_typed;
        row.typed_a          = ta;
        row.typed_b          = tb;
        stim_rows            = {stim_rows, row};
    endtask

    task automatic offer_item(input pfpsm_pkg::in_item_t it, input int gap, input int n_typed,
                              input pfpsm_pkg::out_item_t ta, input pfpsm_pkg::out_item_t tb);
        if (gap != 0) begin
            s_valid <= 1'b0;
            if (gap < 0) begin
                do @(posedge aclk); while (expected_results.size() != 0);
            end else begin
                repeat (gap) @(posedge aclk);
            end
        end
        s_item  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        meter_step(it);
        if (n_typed == 0) begin
            foreach (step_results[i]) expected_results = {expected_results, step_results[i]};
        end else begin
            expected_results = {expected_results, ta};
            if (n_typed > 1) expected_results = {expected_results, tb};
        end
        items_sent++;
        if (it.last_sample) streams_done++;
    endtask

    task automatic write_reg(input logic [pfpsm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [pfpsm_pkg::CFG_DATA_W-1:0] value);
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_index <= idx;
        cfg_wdata <= value;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        meter_config(idx, value);
        cfg_wr_en <= 1'b0;
        writes_done++;
    endtask

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 60) begin
                m_ready   <= 1'b1;
                hold_left <= $urandom_range(0, 8);
            end else if (ready_roll < 90) begin
                m_ready   <= 1'b0;
                hold_left <= $urandom_range(0, 2);
            end else if (ready_roll < 97) begin
                m_ready   <= 1'b1;
                hold_left <= $urandom_range(20, 60);
            end else begin
                m_ready   <= 1'b0;
                hold_left <= $urandom_range(10, 40);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result item, kind %0d frame %0d",
                                          m_item.result_kind, m_item.frame_number));
            end else begin
                oldest = expected_results.pop_front();
                check_field("result_kind", 64'(m_item.result_kind),
                            64'(oldest.result_kind));
                check_field("frame_number", 64'(m_item.frame_number),
                            64'(oldest.frame_number));
                check_field("frame_peak_abs", 64'(m_item.frame_peak_abs),
                            64'(oldest.frame_peak_abs));
                check_field("frame_max_jump", 64'(m_item.frame_max_jump),
                            64'(oldest.frame_max_jump));
                check_field("stream_peak_abs", 64'(m_item.stream_peak_abs),
                            64'(oldest.stream_peak_abs));
                check_field("nonzero_samples", 64'(m_item.nonzero_samples),
                            64'(oldest.nonzero_samples));
                check_field("square_sum", 64'(m_item.square_sum),
                            64'(oldest.square_sum));
                check_field("final_result", 64'(m_item.final_result),
                            64'(oldest.final_result));
                results_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        cfg_channels = pfpsm_pkg::RST_CHANNEL_COUNT;
        cfg_length   = pfpsm_pkg::RST_FRAME_LENGTH;
        cfg_frames   = pfpsm_pkg::RST_FRAME_COUNT;
        meter_restart();

        // Default setting: one frame, so each single-sample stream is easy to read off.
        add_sample(16'h8000, 1'b1, 2, frame_result(16'd0, 16'd32768, 16'd0),
                   totals_result(16'd32768, 32'd1, 63'd1073741824));
        add_sample(16'h7FFF, 1'b1, 2, frame_result(16'd0, 16'd32767, 16'd0),
                   totals_result(16'd32767, 32'd1, 63'd1073676289));
        add_sample(16'h0000, 1'b1, 2, frame_result(16'd0, 16'd0, 16'd0),
                   totals_result(16'd0, 32'd0, 63'd0));

        // One sample per frame, four frames; the tail folds into the last frame.
        add_write(pfpsm_pkg::CFG_CHANNEL_COUNT, 32'd1);
        add_write(pfpsm_pkg::CFG_FRAME_LENGTH, 32'h0001_0000);
        add_write(pfpsm_pkg::CFG_FRAME_COUNT, 32'd4);
        add_sample(16'h8000, 1'b0, 0, '0, '0);
        add_sample(16'h7FFF, 1'b0, 0, '0, '0);
        add_sample(16'h0000, 1'b0, 0, '0, '0);
        add_sample(16'hFFFF, 1'b0, 0, '0, '0);
        add_sample(16'h7FFF, 1'b0, 0, '0, '0);
        add_sample(16'h8000, 1'b1, 2, frame_result(16'd3, 16'd32768, 16'd65535),
                   totals_result(16'd32768, 32'd5, 63'd4294836227));

        // Zero channel count, zero frame count and zero length.
        add_write(pfpsm_pkg::CFG_CHANNEL_COUNT, 32'd0);
        add_write(pfpsm_pkg::CFG_FRAME_COUNT, 32'd0);
        add_write(pfpsm_pkg::CFG_FRAME_LENGTH, 32'd0);
        add_sample(16'd5, 1'b0, 0, '0, '0);
        add_sample(-16'sd5, 1'b0, 0, '0, '0);
        add_sample(16'd7, 1'b1, 0, '0, '0);

        // Channel count above the maximum, longest frames, partial final group.
        add_write(pfpsm_pkg::CFG_CHANNEL_COUNT, 32'd15);
        add_write(pfpsm_pkg::CFG_FRAME_LENGTH, 32'hFFFF_FFFF);
        add_write(pfpsm_pkg::CFG_FRAME_COUNT, 32'd65535);
        for (row_i = 0; row_i < 8; row_i++) add_sample(16'(row_i * 4099 - 9000), 1'b0, 0, '0, '0);
        add_sample(16'h4000, 1'b1, 0, '0, '0);

        // Unused register index, then a short frame raised to the channel count
        // and a stream that ends before its later frames.
        add_write(CFG_UNUSED_INDEX, 32'hA5A5_5A5A);
        add_write(pfpsm_pkg::CFG_CHANNEL_COUNT, 32'd3);
        add_write(pfpsm_pkg::CFG_FRAME_LENGTH, 32'h0001_8000);
        add_write(pfpsm_pkg::CFG_FRAME_COUNT, 32'd3);
        add_sample(16'd100, 1'b0, 0, '0, '0);
        add_sample(-16'sd200, 1'b0, 0, '0, '0);
        add_sample(16'd300, 1'b0, 0, '0, '0);
        add_sample(-16'sd400, 1'b1, 0, '0, '0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_WRITE) begin
                write_reg(stim_rows[i].index, stim_rows[i].value);
            end else begin
                offer_item(stim_rows[i].item, pick_gap(), stim_rows[i].n_typed,
                           stim_rows[i].typed_a, stim_rows[i].typed_b);
            end
        end

        stream_total = items_sent + RANDOM_ITEMS;
        while (items_sent < stream_total) begin
            writes_in_phase = 0;
            if ($urandom_range(0, 9) < 7) begin
                roll = $urandom_range(0, 99);
                if (roll < 7) pick_chans = 0;
                else if (roll < 12) pick_chans = $urandom_range(9, 15);
                else pick_chans = $urandom_range(1, 8);
                if ($urandom_range(0, 4) == 0)
                    write_reg(pfpsm_pkg::CFG_CHANNEL_COUNT,
                              {28'($urandom_range(0, 32'h0FFF_FFFF)), 4'(pick_chans)});
                else
                    write_reg(pfpsm_pkg::CFG_CHANNEL_COUNT, 32'(pick_chans));
                writes_in_phase++;
            end
            if ($urandom_range(0, 9) < 7) begin
                base_len = eff_channels() * 65536;
                roll = $urandom_range(0, 99);
                if (roll < 10)
                    write_reg(pfpsm_pkg::CFG_FRAME_LENGTH, $urandom_range(0, base_len - 1));
                else if (roll < 85)
                    write_reg(pfpsm_pkg::CFG_FRAME_LENGTH,
                              base_len + $urandom_range(0, base_len * 4));
                else if (roll < 95) write_reg(pfpsm_pkg::CFG_FRAME_LENGTH, $urandom());
                else write_reg(pfpsm_pkg::CFG_FRAME_LENGTH, 32'hFFFF_FFFF);
                writes_in_phase++;
            end
            if ($urandom_range(0, 9) < 7 || writes_in_phase == 0) begin
                roll = $urandom_range(0, 99);
                if (roll < 10)
                    write_reg(pfpsm_pkg::CFG_FRAME_COUNT,
                              {16'($urandom_range(0, 65535)), 16'd0});
                else if (roll < 90)
                    write_reg(pfpsm_pkg::CFG_FRAME_COUNT, $urandom_range(1, 8));
                else if (roll < 95) write_reg(pfpsm_pkg::CFG_FRAME_COUNT, 32'd65535);
                else write_reg(pfpsm_pkg::CFG_FRAME_COUNT, $urandom());
            end
            if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED_INDEX, $urandom());

            for (stream_i = $urandom_range(1, 3); stream_i > 0 && items_sent < stream_total;
                 stream_i--) begin
                stream_len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 16)
                                                          : $urandom_range(17, 40);
                if (stream_len > stream_total - items_sent)
                    stream_len = stream_total - items_sent;
                for (smp_i = 0; smp_i < stream_len; smp_i++) begin
                    next_item.sample = pick_sample();
                    // A stream left open on the last pass is cut off by the next write.
                    next_item.last_sample = (smp_i == stream_len - 1) &&
                                            !(stream_i == 1 && $urandom_range(0, 6) == 0);
                    offer_item(next_item, pick_gap(), 0, '0, '0);
                end
            end
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("summary: %0d samples in %0d closed streams, %0d register writes",
                 items_sent, streams_done, writes_done);
        $display("summary: %0d result items compared, %0d mismatches",
                 results_checked, error_count);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
